FILE: hw/rtl/up_down_stopwatch_counter_defines.svh
// ----------------------------------------------------------------------------
// Stopwatch assertion macros
// Shared helpers for writing concurrent checks on clk_i with reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef UP_DOWN_STOPWATCH_COUNTER_DEFINES_SVH
`define UP_DOWN_STOPWATCH_COUNTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UDSW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UDSW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/udsw_pkg.sv
// ----------------------------------------------------------------------------
// Stopwatch package
// Beat types, time limits and the BCD split helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package udsw_pkg;

  localparam int unsigned SecW    = 6;
  localparam int unsigned MinW    = 6;
  localparam int unsigned HourW   = 7;
  localparam int unsigned AdjW    = 6;

  localparam logic [SecW-1:0]  SecMax  = 6'd59;
  localparam logic [MinW-1:0]  MinMax  = 6'd59;
  localparam logic [HourW-1:0] HourMax = 7'd99;

  // Adjust button bit positions.
  localparam int unsigned AdjSecDn  = 0;
  localparam int unsigned AdjSecUp  = 1;
  localparam int unsigned AdjMinDn  = 2;
  localparam int unsigned AdjMinUp  = 3;
  localparam int unsigned AdjHourDn = 4;
  localparam int unsigned AdjHourUp = 5;

  typedef struct packed {
    logic            second_tick;
    logic            clear_strobe;
    logic            pause_strobe;
    logic            resume_strobe;
    logic            direction_button;
    logic [AdjW-1:0] adjust_buttons;
  } udsw_in_t;

  typedef struct packed {
    logic [SecW-1:0]  seconds_value;
    logic [MinW-1:0]  minutes_value;
    logic [HourW-1:0] hours_value;
    logic [3:0]       seconds_ones;
    logic [2:0]       seconds_tens;
    logic [3:0]       minutes_ones;
    logic [2:0]       minutes_tens;
    logic [3:0]       hours_ones;
    logic [3:0]       hours_tens;
    logic             counting_down;
    logic             buzzer_on;
    logic             is_running;
  } udsw_out_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] ones;
  } udsw_bcd_t;

  // Splits a value below 100 into two BCD digits with a compare ladder.
  function automatic udsw_bcd_t bcd_split(logic [6:0] v);
    udsw_bcd_t  r;
    logic [6:0] tens_x10;
    if      (v >= 7'd90) r.tens = 4'd9;
    else if (v >= 7'd80) r.tens = 4'd8;
    else if (v >= 7'd70) r.tens = 4'd7;
    else if (v >= 7'd60) r.tens = 4'd6;
    else if (v >= 7'd50) r.tens = 4'd5;
    else if (v >= 7'd40) r.tens = 4'd4;
    else if (v >= 7'd30) r.tens = 4'd3;
    else if (v >= 7'd20) r.tens = 4'd2;
    else if (v >= 7'd10) r.tens = 4'd1;
    else                 r.tens = 4'd0;
    tens_x10 = 7'({3'd0, r.tens} * 7'd10);
    r.ones   = 4'(v - tens_x10);
    return r;
  endfunction

endpackage

FILE: hw/rtl/up_down_stopwatch_counter.sv
// ----------------------------------------------------------------------------
// Up/down hours:minutes:seconds stopwatch
// Takes one control sample per beat and returns the updated time, its BCD
// digits and the mode flags, one result beat per sample.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake                | Payload
//   --------+-----------+--------------------------+---------------------
//   in      | input     | in_valid_i / in_ready_o  | in_data_i  (udsw_in_t)
//   out     | output    | out_valid_o / out_ready_i| out_data_o (udsw_out_t)
//
// A sample beat is taken every cycle while the result register can move on.
// The sample lands in the input register; when it moves on, the core updates
// its state and the result register loads with the result together.
// The state update is one combinational pass, so back-to-back samples see
// each other's results with no bubble.
// Reset leaves the time at 00:00:00, counting up, running and the alarm off.
// A stall on the output holds the result register and then the input
// register; nothing is dropped or repeated.
`timescale 1ns / 1ps

`include "up_down_stopwatch_counter_defines.svh"

module up_down_stopwatch_counter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  udsw_pkg::udsw_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output udsw_pkg::udsw_out_t out_data_o
);

  // Input register holding the sample that the core works on.
  logic                s1_valid_q;
  udsw_pkg::udsw_in_t  s1_q;

  // Result register on the output side.
  logic                out_valid_q;
  udsw_pkg::udsw_out_t out_q;

  logic                res_ready;
  logic                advance;
  udsw_pkg::udsw_out_t core_result;

  // The result register can take a beat when empty or when being drained.
  assign res_ready  = !out_valid_q || out_ready_i;
  // The core commits its state exactly when its sample moves to the result.
  assign advance    = s1_valid_q && res_ready;
  assign in_ready_o = !s1_valid_q || res_ready;

  udsw_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (s1_q),
    .result_o (core_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= core_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Every delivered time is a legal clock reading.
  `UDSW_ASSERT_SAME(a_time_range, out_valid_o, (out_q.seconds_value <= udsw_pkg::SecMax) && (out_q.minutes_value <= udsw_pkg::MinMax) && (out_q.hours_value <= udsw_pkg::HourMax), "Delivered time is out of range.")

  // The BCD digits agree with the binary seconds and minutes.
  `UDSW_ASSERT_SAME(a_bcd_sec_min, out_valid_o, ((7'(out_q.seconds_tens) * 7'd10 + 7'(out_q.seconds_ones)) == 7'(out_q.seconds_value)) && ((7'(out_q.minutes_tens) * 7'd10 + 7'(out_q.minutes_ones)) == 7'(out_q.minutes_value)), "Seconds or minutes digits disagree with the value.")

  // The BCD digits agree with the binary hours.
  `UDSW_ASSERT_SAME(a_bcd_hours, out_valid_o, (7'(7'(out_q.hours_tens) * 7'd10) + 7'(out_q.hours_ones)) == out_q.hours_value, "Hours digits disagree with the value.")

  // A sample that cannot move on stays in the input register untouched.
  `UDSW_ASSERT_NEXT(a_s1_hold, s1_valid_q && !res_ready, s1_valid_q && $stable(s1_q), "Stalled sample was lost or changed.")

endmodule

FILE: hw/rtl/udsw_core.sv
// ----------------------------------------------------------------------------
// Stopwatch core
// Time and control state with the combinational update for one sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module udsw_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  udsw_pkg::udsw_in_t item_i,
  output udsw_pkg::udsw_out_t result_o
);

  logic [udsw_pkg::SecW-1:0]  sec_q, sec_d;
  logic [udsw_pkg::MinW-1:0]  min_q, min_d;
  logic [udsw_pkg::HourW-1:0] hour_q, hour_d;
  logic                       down_q, down_d;
  logic                       run_q, run_d;
  logic                       alarm_q, alarm_d;
  logic [udsw_pkg::AdjW-1:0]  held_q, held_d;
  logic                       dir_prev_q, dir_prev_d;

  logic [udsw_pkg::AdjW-1:0]  pressed;
  logic [udsw_pkg::AdjW-1:0]  press_rise;
  udsw_pkg::udsw_bcd_t        sec_bcd, min_bcd, hour_bcd;

  always_comb begin
    sec_d      = item_i.clear_strobe ? '0 : sec_q;
    min_d      = item_i.clear_strobe ? '0 : min_q;
    hour_d     = item_i.clear_strobe ? '0 : hour_q;
    run_d      = run_q;
    alarm_d    = alarm_q;
    down_d     = down_q;
    pressed    = ~item_i.adjust_buttons;
    press_rise = pressed & ~held_q;
    held_d     = pressed;
    dir_prev_d = item_i.direction_button;

    // Pause is applied before resume, so both together leave it running.
    if (item_i.pause_strobe) run_d = 1'b0;
    if (item_i.resume_strobe) run_d = 1'b1;

    if (item_i.second_tick && run_d) begin
      if (down_q) begin
        if (sec_d != '0) begin
          sec_d = sec_d - 1'b1;
        end else if (min_d != '0) begin
          min_d = min_d - 1'b1;
          sec_d = udsw_pkg::SecMax;
        end else if (hour_d != '0) begin
          hour_d = hour_d - 1'b1;
          min_d  = udsw_pkg::MinMax;
          sec_d  = udsw_pkg::SecMax;
        end else begin
          alarm_d = 1'b1;
        end
      end else begin
        alarm_d = 1'b0;
        if (sec_d == udsw_pkg::SecMax) begin
          sec_d = '0;
          if (min_d == udsw_pkg::MinMax) begin
            min_d  = '0;
            hour_d = (hour_d == udsw_pkg::HourMax) ? '0 : hour_d + 1'b1;
          end else begin
            min_d = min_d + 1'b1;
          end
        end else begin
          sec_d = sec_d + 1'b1;
        end
      end
    end

    // The direction toggles on the press of its button.
    if (!item_i.direction_button && dir_prev_q) down_d = ~down_q;

    if (press_rise[udsw_pkg::AdjSecDn] && sec_d != '0) sec_d = sec_d - 1'b1;
    if (press_rise[udsw_pkg::AdjSecUp] && sec_d < udsw_pkg::SecMax) sec_d = sec_d + 1'b1;
    if (press_rise[udsw_pkg::AdjMinDn] && min_d != '0) min_d = min_d - 1'b1;
    if (press_rise[udsw_pkg::AdjMinUp] && min_d < udsw_pkg::MinMax) min_d = min_d + 1'b1;
    if (press_rise[udsw_pkg::AdjHourDn] && hour_d != '0) hour_d = hour_d - 1'b1;
    if (press_rise[udsw_pkg::AdjHourUp] && hour_d < udsw_pkg::HourMax) begin
      hour_d = hour_d + 1'b1;
    end
  end

  always_comb begin
    sec_bcd  = udsw_pkg::bcd_split({1'b0, sec_d});
    min_bcd  = udsw_pkg::bcd_split({1'b0, min_d});
    hour_bcd = udsw_pkg::bcd_split(hour_d);

    result_o.seconds_value = sec_d;
    result_o.minutes_value = min_d;
    result_o.hours_value   = hour_d;
    result_o.seconds_ones  = sec_bcd.ones;
    result_o.seconds_tens  = sec_bcd.tens[2:0];
    result_o.minutes_ones  = min_bcd.ones;
    result_o.minutes_tens  = min_bcd.tens[2:0];
    result_o.hours_ones    = hour_bcd.ones;
    result_o.hours_tens    = hour_bcd.tens;
    result_o.counting_down = down_d;
    result_o.buzzer_on     = alarm_d;
    result_o.is_running    = run_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q      <= '0;
      min_q      <= '0;
      hour_q     <= '0;
      down_q     <= 1'b0;
      run_q      <= 1'b1;
      alarm_q    <= 1'b0;
      held_q     <= '0;
      dir_prev_q <= 1'b1;
    end else if (step_i) begin
      sec_q      <= sec_d;
      min_q      <= min_d;
      hour_q     <= hour_d;
      down_q     <= down_d;
      run_q      <= run_d;
      alarm_q    <= alarm_d;
      held_q     <= held_d;
      dir_prev_q <= dir_prev_d;
    end
  end

endmodule
